FILE: sv/bqlp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the multichannel biquad low-pass block.
// No dependencies.
package bqlp_pkg;

    localparam int CHANNELS       = 16;
    localparam int COEF_FRAC_BITS = 22;
    localparam int COEF_W         = 24;
    localparam int SAMPLE_W       = 16;
    localparam int CHAN_W         = 4;
    localparam int PROD_W         = COEF_W + SAMPLE_W;
    localparam int ACC_W          = 48;
    localparam int CFG_IDX_W      = 2;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = 1;
    localparam int QCNT_W         = 2;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 2'd2;

    localparam logic signed [COEF_W-1:0] COEF_B0_RST = 24'sd193769;
    localparam logic signed [COEF_W-1:0] COEF_A1_RST = -24'sd5480811;
    localparam logic signed [COEF_W-1:0] COEF_A2_RST = 24'sd2061593;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = 48'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX    = 48'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_MIN    = -48'sd32768;

    typedef struct packed {
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       restart;
        logic                       in_range;
    } bqlp_req_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } bqlp_coef_t;

endpackage

FILE: sv/bqlp_front.sv
`timescale 1ns / 1ps
// Front end: accepts input samples, classifies them and queues requests.
// Depends on bqlp_pkg.
module bqlp_front
    import bqlp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CHAN_W-1:0]          channel,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       restart,
    output logic                       req_valid,
    input  logic                       req_ready,
    output bqlp_req_t                  req
);

    bqlp_req_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg;
    logic [QCNT_W-1:0]     count_next;
    logic                  push;
    logic                  pop;
    bqlp_req_t             incoming;

    always_comb
    begin
        incoming.channel  = channel;
        incoming.sample   = sample_in;
        incoming.restart  = restart;
        incoming.in_range = ({1'b0, channel} < (CHAN_W + 1)'(CHANNELS));
    end

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign req_valid = (count_reg != '0);
    assign req       = queue_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = req_valid && req_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold request payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

FILE: sv/bqlp_back.sv
`timescale 1ns / 1ps
// Back end: per-channel history, biquad datapath, rounding, saturation and
// the output register. Depends on bqlp_pkg.
module bqlp_back
    import bqlp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  bqlp_req_t                   req,
    input  bqlp_coef_t                  coef,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [CHAN_W-1:0]           channel_out,
    output logic signed [SAMPLE_W-1:0]  sample_out,
    output logic                        clipped
);

    logic signed [SAMPLE_W-1:0] x1_hist_reg [CHANNELS];
    logic signed [SAMPLE_W-1:0] x2_hist_reg [CHANNELS];
    logic signed [SAMPLE_W-1:0] y1_hist_reg [CHANNELS];
    logic signed [SAMPLE_W-1:0] y2_hist_reg [CHANNELS];

    logic                       out_valid_reg;
    logic [CHAN_W-1:0]          chan_out_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       clipped_reg;

    logic                       fire;
    logic                       use_hist;
    logic signed [SAMPLE_W-1:0] x0;
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
    logic signed [PROD_W-1:0]   p0;
    logic signed [PROD_W-1:0]   p1;
    logic signed [PROD_W-1:0]   p2;
    logic signed [PROD_W-1:0]   p3;
    logic signed [PROD_W-1:0]   p4;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    y_full;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic                       clip;

    assign req_ready = !out_valid_reg || out_ready;
    assign fire      = req_valid && req_ready;
    assign use_hist  = req.in_range && !req.restart;

    always_comb
    begin
        x0 = req.sample;
        x1 = use_hist ? x1_hist_reg[req.channel] : '0;
        x2 = use_hist ? x2_hist_reg[req.channel] : '0;
        y1 = use_hist ? y1_hist_reg[req.channel] : '0;
        y2 = use_hist ? y2_hist_reg[req.channel] : '0;
    end

    assign p0 = coef.b0 * x0;
    assign p1 = coef.b0 * x1;
    assign p2 = coef.b0 * x2;
    assign p3 = coef.a1 * y1;
    assign p4 = coef.a2 * y2;

    always_comb
    begin
        acc = ACC_W'(p0) + (ACC_W'(p1) <<< 1) + ACC_W'(p2) - ACC_W'(p3) - ACC_W'(p4);
        y_full = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
        clip   = 1'b0;
        y_sat  = y_full[SAMPLE_W-1:0];
        if (y_full > SAT_MAX)
        begin
            y_sat = SAT_MAX[SAMPLE_W-1:0];
            clip  = 1'b1;
        end
        else if (y_full < SAT_MIN)
        begin
            y_sat = SAT_MIN[SAMPLE_W-1:0];
            clip  = 1'b1;
        end
    end

    // advance channel history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                x1_hist_reg[i] <= '0;
                x2_hist_reg[i] <= '0;
                y1_hist_reg[i] <= '0;
                y2_hist_reg[i] <= '0;
            end
        end
        else if (fire && req.in_range)
        begin
            x1_hist_reg[req.channel] <= x0;
            x2_hist_reg[req.channel] <= x1;
            y1_hist_reg[req.channel] <= y_sat;
            y2_hist_reg[req.channel] <= y1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            out_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            chan_out_reg   <= req.channel;
            sample_out_reg <= y_sat;
            clipped_reg    <= clip;
        end
    end

    assign out_valid   = out_valid_reg;
    assign channel_out = chan_out_reg;
    assign sample_out  = sample_out_reg;
    assign clipped     = clipped_reg;

endmodule

FILE: sv/multichannel_biquad_lowpass_top.sv
`timescale 1ns / 1ps
// Top level of the multichannel biquad low-pass filter: coefficient registers,
// front end and back end. Depends on bqlp_pkg, bqlp_front and bqlp_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one request per sample, carrying the
//   channel number, a signed 16-bit sample and a restart flag that clears the
//   channel's history before filtering.
//   Output channel (out_valid/out_ready): one filtered sample per request, in
//   request order, with its channel number and a clipped flag.
//   Configuration: write cfg_wdata to coefficient cfg_index (b0, a1, a2) with
//   cfg_we; write only while no request is in flight. Other indexes are dropped.
//   Path: an accepted request is first written into the request queue, then
//   into the output register when the back end takes it from the queue.
//   Throughput: one sample per cycle while out_ready stays high; the whole biquad
//   sum, rounding and history update run in one registered pass of the back end.
//   Reset: all channel histories clear to zero, coefficients return to their
//   default Butterworth values, both channels go empty.
//   Stall: when out_ready is low the output register holds; the two-entry
//   request queue keeps taking input until it fills, then in_ready drops.
module multichannel_biquad_lowpass_top
    import bqlp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [CHAN_W-1:0]           channel,
    input  logic signed [SAMPLE_W-1:0]  sample_in,
    input  logic                        restart,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [CHAN_W-1:0]           channel_out,
    output logic signed [SAMPLE_W-1:0]  sample_out,
    output logic                        clipped,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [COEF_W-1:0]           cfg_wdata
);

    bqlp_coef_t coef_reg;
    bqlp_req_t  req;
    logic       req_valid;
    logic       req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= COEF_B0_RST;
            coef_reg.a1 <= COEF_A1_RST;
            coef_reg.a2 <= COEF_A2_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COEF_B0: coef_reg.b0 <= signed'(cfg_wdata);
                REG_COEF_A1: coef_reg.a1 <= signed'(cfg_wdata);
                REG_COEF_A2: coef_reg.a2 <= signed'(cfg_wdata);
                default:     coef_reg    <= coef_reg;
            endcase
        end
    end

    bqlp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .channel   (channel),
        .sample_in (sample_in),
        .restart   (restart),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    bqlp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .coef        (coef_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .channel_out (channel_out),
        .sample_out  (sample_out),
        .clipped     (clipped)
    );

endmodule
